[hw/rtl/phd_pkg.sv]
// shared types, constants and the strength-to-duty map of the proximity haptic driver
package phd_pkg;

    localparam int PHD_WINDOW = 3;

    localparam int RSSI_W = 8;
    localparam int TYPE_W = 8;
    localparam int DUTY_W = 8;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [RSSI_W-1:0] RSSI_NONE = -8'sd100;
    localparam logic signed [RSSI_W-1:0] RSSI_LOSS = -8'sd90;
    localparam logic signed [RSSI_W-1:0] RSSI_FULL = -8'sd42;

    localparam logic [TYPE_W-1:0] TYPE_NONE   = 8'd45;
    localparam logic [TYPE_W-1:0] TYPE_WALL   = 8'd87;
    localparam logic [TYPE_W-1:0] TYPE_STAIRS = 8'd83;

    localparam logic [DUTY_W-1:0] DUTY_FULL   = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_STAIRS = 8'd200;
    localparam logic [DUTY_W-1:0] DUTY_OFF    = 8'd0;

    localparam logic [CFG_W-1:0] PULSE_ON_RST  = 16'd80;
    localparam logic [CFG_W-1:0] PULSE_GAP_RST = 16'd80;
    localparam logic [CFG_W-1:0] PAUSE_RST     = 16'd300;
    localparam logic [CFG_W-1:0] ELAPSED_MAX   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_GAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE     = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_FOUND = 2'd1,
        CMD_LOSS  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ON1   = 3'd1,
        PH_GAP   = 3'd2,
        PH_ON2   = 3'd3,
        PH_PAUSE = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RING,
        S_SUM,
        S_DIV_INIT,
        S_DIV,
        S_COMMIT,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic ring_wr;
        logic sum_step;
        logic div_start;
        logic div_step;
        logic commit;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic sum_last;
        logic div_last;
        logic out_free;
    } t_dp_status;

    // piecewise-linear duty map, divisions by three folded into the table
    function automatic logic [DUTY_W-1:0] map_strength(input logic signed [RSSI_W-1:0] h);
        logic [DUTY_W-1:0] duty;
        if (h >= RSSI_FULL) begin
            duty = DUTY_FULL;
        end else begin
            case (h)
                -8'sd43: duty = 8'd236;
                -8'sd44: duty = 8'd218;
                -8'sd45: duty = 8'd200;
                -8'sd46: duty = 8'd173;
                -8'sd47: duty = 8'd146;
                -8'sd48: duty = 8'd120;
                -8'sd49: duty = 8'd90;
                -8'sd50: duty = 8'd60;
                default: duty = DUTY_OFF;
            endcase
        end
        return duty;
    endfunction

endpackage

[hw/rtl/phd_ctrl.sv]
// sequencing state machine of the proximity haptic driver
module phd_ctrl import phd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_command,
    output logic               o_ready,
    input  t_dp_status         i_status,
    output t_dp_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = (i_command == CMD_FOUND) ? S_RING : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_OUT;
            end
            S_RING: begin
                o_cmd.ring_wr = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_step = 1'b1;
                if (i_status.sum_last) n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/phd_dp.sv]
// datapath of the proximity haptic driver: ring, averaging divider, pulse pattern, outputs
module phd_dp import phd_pkg::*; #(
    parameter int WINDOW = PHD_WINDOW
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic [1:0]                 i_command,
    input  logic signed [RSSI_W-1:0]   i_raw_rssi,
    input  logic [TYPE_W-1:0]          i_type_char,
    input  logic                       i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [DUTY_W-1:0]          o_motor_pwm,
    output logic                       o_type_line,
    output logic signed [RSSI_W-1:0]   o_smoothed_rssi,
    output logic                       o_target_lost
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = RSSI_W + CNT_W;
    localparam int BIT_W = $clog2(SUM_W);

    // configuration
    logic [CFG_W-1:0] r_pulse_on;
    logic [CFG_W-1:0] r_pulse_gap;
    logic [CFG_W-1:0] r_pause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_on  <= PULSE_ON_RST;
            r_pulse_gap <= PULSE_GAP_RST;
            r_pause     <= PAUSE_RST;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                REG_PULSE_ON:  r_pulse_on  <= i_cfg_data;
                REG_PULSE_GAP: r_pulse_gap <= i_cfg_data;
                REG_PAUSE:     r_pause     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched request
    logic [1:0]                r_command;
    logic signed [RSSI_W-1:0]  r_raw;
    logic [TYPE_W-1:0]         r_type;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_command <= i_command;
            r_raw     <= i_raw_rssi;
            r_type    <= i_type_char;
        end
    end

    // history ring and accumulation
    logic signed [RSSI_W-1:0] r_ring [WINDOW];
    logic [IDX_W-1:0]         r_widx;
    logic [IDX_W-1:0]         r_ptr;
    logic signed [SUM_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [RSSI_W-1:0] ring_rd;
    logic                     sum_last;

    assign ring_rd  = r_ring[r_ptr];
    assign sum_last = (r_ptr == IDX_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) r_ring[k] <= RSSI_NONE;
            r_widx <= '0;
        end else if (i_cmd.ring_wr) begin
            r_ring[r_widx] <= r_raw;
            r_widx <= (r_widx == IDX_W'(WINDOW - 1)) ? '0 : r_widx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_wr) begin
            r_ptr <= '0;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.sum_step) begin
            if (ring_rd != RSSI_NONE) begin
                r_acc <= r_acc + SUM_W'(ring_rd);
                r_cnt <= r_cnt + 1'b1;
            end
            if (!sum_last) r_ptr <= r_ptr + 1'b1;
        end
    end

    // restoring divider on the magnitude, quotient shifts into r_dvd
    logic [SUM_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [BIT_W-1:0]  r_bit;
    logic              r_neg;
    logic              r_empty;
    logic [SUM_W-1:0]  acc_mag;
    logic [CNT_W:0]    trial;
    logic              q_bit;

    assign acc_mag = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);
    assign trial   = {r_rem, r_dvd[SUM_W-1]};
    assign q_bit   = (trial >= {1'b0, r_cnt});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dvd   <= acc_mag;
            r_rem   <= '0;
            r_bit   <= BIT_W'(SUM_W - 1);
            r_neg   <= r_acc[SUM_W-1];
            r_empty <= (r_cnt == '0);
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? CNT_W'(trial - {1'b0, r_cnt}) : trial[CNT_W-1:0];
            r_dvd <= {r_dvd[SUM_W-2:0], q_bit};
            r_bit <= r_bit - 1'b1;
        end
    end

    logic [RSSI_W-1:0] quot;
    logic [RSSI_W-1:0] avg;

    assign quot = r_dvd[RSSI_W-1:0];
    assign avg  = r_empty ? RSSI_NONE : (r_neg ? RSSI_W'(-quot) : quot);

    // held target and pulse pattern
    logic signed [RSSI_W-1:0] r_held_rssi;
    logic [TYPE_W-1:0]        r_held_type;
    t_phase                   r_phase;
    logic [CFG_W-1:0]         r_elapsed;
    logic [DUTY_W-1:0]        r_level;
    logic                     r_tline;
    logic                     r_lost;

    t_phase            n_phase;
    logic [CFG_W-1:0]  n_elapsed;
    logic [DUTY_W-1:0] n_level;
    logic              n_tline;
    logic [DUTY_W-1:0] target;
    logic [CFG_W-1:0]  elapsed_inc;

    assign target      = map_strength(r_held_rssi);
    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = elapsed_inc;
        n_level   = r_level;
        n_tline   = 1'b0;
        if (target != DUTY_OFF && r_held_type == TYPE_WALL) begin
            n_tline = 1'b1;
            n_level = DUTY_FULL;
        end else if (target != DUTY_OFF && r_held_type == TYPE_STAIRS) begin
            case (r_phase)
                PH_ON1: begin
                    if (elapsed_inc >= r_pulse_on) begin
                        n_phase = PH_GAP; n_level = DUTY_OFF; n_elapsed = '0;
                    end
                end
                PH_GAP: begin
                    if (elapsed_inc >= r_pulse_gap) begin
                        n_phase = PH_ON2; n_level = DUTY_STAIRS; n_elapsed = '0;
                    end
                end
                PH_ON2: begin
                    if (elapsed_inc >= r_pulse_on) begin
                        n_phase = PH_PAUSE; n_level = DUTY_OFF; n_elapsed = '0;
                    end
                end
                PH_PAUSE: begin
                    if (elapsed_inc >= r_pause) n_phase = PH_IDLE;
                end
                default: begin
                    n_phase = PH_ON1; n_level = DUTY_STAIRS; n_elapsed = '0;
                end
            endcase
        end else begin
            n_level = target;
            if (r_held_type != TYPE_STAIRS) n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_rssi <= RSSI_NONE;
            r_held_type <= TYPE_NONE;
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_level     <= DUTY_OFF;
            r_tline     <= 1'b0;
            r_lost      <= 1'b0;
        end else begin
            if (i_cmd.load_in) r_lost <= 1'b0;
            if (i_cmd.exec) begin
                case (r_command)
                    CMD_TICK: begin
                        r_phase   <= n_phase;
                        r_elapsed <= n_elapsed;
                        r_level   <= n_level;
                        r_tline   <= n_tline;
                    end
                    CMD_LOSS: begin
                        if (r_held_rssi > RSSI_LOSS) begin
                            r_held_rssi <= RSSI_NONE;
                            r_held_type <= TYPE_NONE;
                            r_lost      <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_held_rssi <= avg;
                r_held_type <= r_type;
            end
        end
    end

    // output register
    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_out_pwm;
    logic                     r_out_tline;
    logic signed [RSSI_W-1:0] r_out_rssi;
    logic                     r_out_lost;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pwm   <= r_level;
            r_out_tline <= r_tline;
            r_out_rssi  <= r_held_rssi;
            r_out_lost  <= r_lost;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_motor_pwm     = r_out_pwm;
    assign o_type_line     = r_out_tline;
    assign o_smoothed_rssi = r_out_rssi;
    assign o_target_lost   = r_out_lost;

    assign o_status.sum_last = sum_last;
    assign o_status.div_last = (r_bit == '0);
    assign o_status.out_free = !r_out_valid || i_ready;

endmodule

[hw/rtl/proximity_haptic_driver_top.sv]
// top level of the proximity haptic driver: controller plus datapath
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+------------------------------------------
//  request   | i_valid      | o_ready      | i_command, i_raw_rssi, i_type_char
//  result    | o_valid      | i_ready      | o_motor_pwm, o_type_line,
//            |              |              | o_smoothed_rssi, o_target_lost
//  config    | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// tick, no-target and unknown requests pass the execute state, then the result load
// a target-found request runs the averaging path before the commit and result load:
//   one ring write, one accumulate step per ring entry, then a one-bit-per-cycle
//   restoring divider over the sum width
// one request at a time; the result sits in an output register, so a stalled
// result holds back only the load of the next one
// synchronous active-low reset; no clearing pass, config port is always ready
module proximity_haptic_driver_top import phd_pkg::*; #(
    parameter int WINDOW = PHD_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_command,
    input  logic signed [RSSI_W-1:0] i_raw_rssi,
    input  logic [TYPE_W-1:0]        i_type_char,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DUTY_W-1:0]        o_motor_pwm,
    output logic                     o_type_line,
    output logic signed [RSSI_W-1:0] o_smoothed_rssi,
    output logic                     o_target_lost,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // config writes are registered directly, never stalled
    assign o_cfg_ready = 1'b1;

    // sequencer: decides which datapath step runs each cycle
    phd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    // smoothing ring, divider, pulse pattern and result register
    phd_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .i_command       (i_command),
        .i_raw_rssi      (i_raw_rssi),
        .i_type_char     (i_type_char),
        .i_cfg_wr        (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_motor_pwm     (o_motor_pwm),
        .o_type_line     (o_type_line),
        .o_smoothed_rssi (o_smoothed_rssi),
        .o_target_lost   (o_target_lost)
    );

endmodule
